// ===== design/mitt_pkg.sv =====
// Shared types, constants and the base/wrap counter step for the interval timer.
package mitt_pkg;

    localparam int unsigned BASE_W       = 14;
    localparam int unsigned LONG_W       = 13;
    localparam int unsigned SHORT_W      = 8;
    localparam int unsigned WINDOW_W     = 16;
    localparam int unsigned EVENTS_W     = 8;
    localparam int unsigned HOLD_W       = 4;
    localparam int unsigned START_W      = 4;
    localparam int unsigned CFG_DATA_W   = 14;
    localparam int unsigned CFG_INDEX_W  = 3;

    localparam logic [BASE_W-1:0]   BASE_PERIOD_RST     = 14'd12000;
    localparam logic [LONG_W-1:0]   LONG_LIMIT_RST      = 13'd4320;
    localparam logic [SHORT_W-1:0]  MEDIUM_LIMIT_RST    = 8'd30;
    localparam logic [SHORT_W-1:0]  SHORT_LIMIT_RST     = 8'd10;
    localparam logic [EVENTS_W-1:0] ALARM_THRESHOLD_RST = 8'd20;
    localparam logic [SHORT_W-1:0]  COMP_STEP_RST       = 8'd40;

    localparam logic [HOLD_W-1:0]   HOLD_RELEASE = 4'd3;
    localparam logic [HOLD_W-1:0]   HOLD_MAX     = 4'd15;
    localparam logic [HOLD_W-1:0]   HOLD_PRESET  = 4'd5;
    localparam logic [EVENTS_W-1:0] EVENTS_MAX   = 8'd255;

    localparam logic OP_TICK       = 1'b0;
    localparam logic OP_COMPENSATE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_PERIOD     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_LIMIT      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_LIMIT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LIMIT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_THRESHOLD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COMP_STEP       = 3'd5;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [LONG_W-1:0] wraps;
        logic              pulse;
    } pair_step_t;

    // One step of a base/wrap counter pair. Narrower wrap counters are
    // zero-extended by the caller; their result always fits back.
    function automatic pair_step_t advance_pair(
        input logic [BASE_W-1:0]  base,
        input logic [LONG_W-1:0]  wraps,
        input logic [LONG_W-1:0]  limit,
        input logic [SHORT_W-1:0] add,
        input logic               tick,
        input logic [BASE_W-1:0]  period
    );
        logic [BASE_W:0] sum;
        logic [LONG_W:0] wraps_inc;
        pair_step_t      res;
        sum       = {1'b0, base} + {{(BASE_W + 1 - SHORT_W){1'b0}}, add};
        wraps_inc = {1'b0, wraps} + {{LONG_W{1'b0}}, 1'b1};
        res.wraps = wraps;
        res.pulse = 1'b0;
        if (sum > {1'b0, period}) begin
            if (tick) begin
                sum = '0;
            end
            else begin
                sum = sum - {1'b0, period};
            end
            if (wraps_inc > {1'b0, limit}) begin
                res.wraps = '0;
                res.pulse = 1'b1;
            end
            else begin
                res.wraps = wraps_inc[LONG_W-1:0];
            end
        end
        res.base = sum[BASE_W-1:0];
        return res;
    endfunction

endpackage

// ===== design/multi_interval_tick_timer.sv =====
// Top level of the multi-interval tick timer: input register, update logic, result register.
// The timer takes one beat per clock cycle while item_stall is low and returns one result beat
// per input beat, in order. An accepted beat first lands in an input register; once the
// result register is empty or its beat is being taken, a single pass of counter logic
// updates all timer state and loads the result register. That result register is the only
// buffering on the output side, so while a result waits under result_stall the input
// register still holds one more beat, and item_stall rises only when both are full.
// Configuration writes take effect at once and are meant for idle periods only.
module multi_interval_tick_timer #(
    parameter int unsigned SENSOR_CHANNELS = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port.
    input  logic                                 cfg_write,
    input  logic [mitt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mitt_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Input channel.
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 opcode,
    input  logic                                 power_down,
    input  logic                                 charging,
    input  logic                                 alarm_event,
    input  logic [mitt_pkg::START_W-1:0]         sensor_start,
    // Result channel.
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic                                 long_elapsed,
    output logic                                 medium_elapsed,
    output logic                                 short_elapsed,
    output logic                                 window_done,
    output logic                                 battery_alarm,
    output logic [mitt_pkg::START_W-1:0]         sensor_release
);
    import mitt_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [BASE_W-1:0]   base_period_reg;
    logic [LONG_W-1:0]   long_limit_reg;
    logic [SHORT_W-1:0]  medium_limit_reg;
    logic [SHORT_W-1:0]  short_limit_reg;
    logic [EVENTS_W-1:0] alarm_threshold_reg;
    logic [SHORT_W-1:0]  comp_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_period_reg     <= BASE_PERIOD_RST;
            long_limit_reg      <= LONG_LIMIT_RST;
            medium_limit_reg    <= MEDIUM_LIMIT_RST;
            short_limit_reg     <= SHORT_LIMIT_RST;
            alarm_threshold_reg <= ALARM_THRESHOLD_RST;
            comp_step_reg       <= COMP_STEP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BASE_PERIOD:     base_period_reg     <= cfg_data;
                REG_LONG_LIMIT:      long_limit_reg      <= cfg_data[LONG_W-1:0];
                REG_MEDIUM_LIMIT:    medium_limit_reg    <= cfg_data[SHORT_W-1:0];
                REG_SHORT_LIMIT:     short_limit_reg     <= cfg_data[SHORT_W-1:0];
                REG_ALARM_THRESHOLD: alarm_threshold_reg <= cfg_data[EVENTS_W-1:0];
                REG_COMP_STEP:       comp_step_reg       <= cfg_data[SHORT_W-1:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake control. The input register moves forward whenever the
    // result register is empty or its beat is being taken.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic result_valid_reg;
    logic s1_advance;
    logic s1_fire;
    logic item_take;

    assign s1_advance = !result_valid_reg || !result_stall;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign item_stall = s1_valid_reg && !s1_advance;
    assign item_take  = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                result_valid_reg <= s1_valid_reg;
            end
            if (item_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Input payload register; no reset needed.
    logic               s1_opcode_reg;
    logic               s1_power_down_reg;
    logic               s1_charging_reg;
    logic               s1_alarm_event_reg;
    logic [START_W-1:0] s1_sensor_start_reg;

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_opcode_reg       <= opcode;
            s1_power_down_reg   <= power_down;
            s1_charging_reg     <= charging;
            s1_alarm_event_reg  <= alarm_event;
            s1_sensor_start_reg <= sensor_start;
        end
    end

    // ------------------------------------------------------------------
    // Timer state.
    // ------------------------------------------------------------------
    logic [BASE_W-1:0]   long_base_reg,   long_base_next;
    logic [LONG_W-1:0]   long_wraps_reg,  long_wraps_next;
    logic [BASE_W-1:0]   medium_base_reg, medium_base_next;
    logic [SHORT_W-1:0]  medium_wraps_reg, medium_wraps_next;
    logic [BASE_W-1:0]   short_base_reg,  short_base_next;
    logic [SHORT_W-1:0]  short_wraps_reg, short_wraps_next;
    logic [WINDOW_W-1:0] window_count_reg, window_count_next;
    logic [EVENTS_W-1:0] alarm_events_reg, alarm_events_next;
    logic                alarm_level_reg, alarm_level_next;
    logic [HOLD_W-1:0]   hold_reg  [SENSOR_CHANNELS];
    logic [HOLD_W-1:0]   hold_next [SENSOR_CHANNELS];

    // Result bits produced by the pass.
    logic               long_pulse_next;
    logic               medium_pulse_next;
    logic               short_pulse_next;
    logic               window_done_next;
    logic [START_W-1:0] release_next;

    logic is_tick;
    logic is_comp;
    assign is_comp = (s1_opcode_reg == OP_COMPENSATE);
    assign is_tick = (s1_opcode_reg == OP_TICK) && !s1_power_down_reg;

    // Base/wrap pairs. A compensate beat adds the configured step and wraps
    // by subtraction; a running tick adds one and wraps to zero.
    pair_step_t         long_step;
    pair_step_t         medium_step;
    pair_step_t         short_step;
    logic [SHORT_W-1:0] pair_add;

    assign pair_add = is_comp ? comp_step_reg : {{(SHORT_W - 1){1'b0}}, 1'b1};

    always_comb
    begin
        long_step   = advance_pair(long_base_reg, long_wraps_reg, long_limit_reg,
                                   pair_add, !is_comp, base_period_reg);
        medium_step = advance_pair(medium_base_reg,
                                   {{(LONG_W - SHORT_W){1'b0}}, medium_wraps_reg},
                                   {{(LONG_W - SHORT_W){1'b0}}, medium_limit_reg},
                                   pair_add, !is_comp, base_period_reg);
        short_step  = advance_pair(short_base_reg,
                                   {{(LONG_W - SHORT_W){1'b0}}, short_wraps_reg},
                                   {{(LONG_W - SHORT_W){1'b0}}, short_limit_reg},
                                   pair_add, !is_comp, base_period_reg);
    end

    always_comb
    begin
        long_base_next    = long_base_reg;
        long_wraps_next   = long_wraps_reg;
        medium_base_next  = medium_base_reg;
        medium_wraps_next = medium_wraps_reg;
        short_base_next   = short_base_reg;
        short_wraps_next  = short_wraps_reg;
        long_pulse_next   = 1'b0;
        medium_pulse_next = 1'b0;
        short_pulse_next  = 1'b0;
        if (is_comp || is_tick)
        begin
            long_base_next    = long_step.base;
            long_wraps_next   = long_step.wraps;
            long_pulse_next   = long_step.pulse;
            medium_base_next  = medium_step.base;
            medium_wraps_next = medium_step.wraps[SHORT_W-1:0];
            medium_pulse_next = medium_step.pulse;
            short_base_next   = short_step.base;
            short_wraps_next  = short_step.wraps[SHORT_W-1:0];
            short_pulse_next  = short_step.pulse;
        end
    end

    // Charging window and battery alarm. The event of this beat is counted
    // before the window end is evaluated, even while powered down.
    logic [EVENTS_W-1:0] events_bumped;
    logic [WINDOW_W:0]   window_inc;

    assign events_bumped = (s1_alarm_event_reg && (alarm_events_reg < EVENTS_MAX))
                           ? alarm_events_reg + {{(EVENTS_W - 1){1'b0}}, 1'b1}
                           : alarm_events_reg;
    assign window_inc    = {1'b0, window_count_reg} + {{WINDOW_W{1'b0}}, 1'b1};

    always_comb
    begin
        window_count_next = window_count_reg;
        alarm_events_next = events_bumped;
        alarm_level_next  = alarm_level_reg;
        window_done_next  = 1'b0;
        if (is_comp && s1_charging_reg)
        begin
            // No end-of-window check here; the count simply rolls over.
            window_count_next = window_count_reg
                                + {{(WINDOW_W - SHORT_W){1'b0}}, comp_step_reg};
        end
        else if (is_tick && s1_charging_reg)
        begin
            if (window_inc > {{(WINDOW_W + 1 - BASE_W){1'b0}}, base_period_reg})
            begin
                window_count_next = '0;
                window_done_next  = 1'b1;
                alarm_level_next  = (events_bumped > alarm_threshold_reg);
                alarm_events_next = '0;
            end
            else
            begin
                window_count_next = window_inc[WINDOW_W-1:0];
            end
        end
    end

    // Sensor hold counters. Only the first four channels see a start bit or
    // drive a release bit; any further channels just count.
    logic [SENSOR_CHANNELS-1:0] rel_ch;

    for (genvar g = 0; g < SENSOR_CHANNELS; g++)
    begin : g_hold
        logic start_hit;
        logic [HOLD_W-1:0] cleared;

        if (g < START_W)
        begin : g_start
            assign start_hit = s1_sensor_start_reg[g];
        end
        else
        begin : g_nostart
            assign start_hit = 1'b0;
        end

        assign cleared = start_hit ? '0 : hold_reg[g];

        always_comb
        begin
            hold_next[g] = cleared;
            rel_ch[g]    = 1'b0;
            if (is_comp)
            begin
                hold_next[g] = HOLD_PRESET;
            end
            else if (is_tick)
            begin
                if (cleared < HOLD_MAX)
                begin
                    hold_next[g] = cleared + {{(HOLD_W - 1){1'b0}}, 1'b1};
                end
                rel_ch[g] = (hold_next[g] > HOLD_RELEASE);
            end
        end
    end

    for (genvar k = 0; k < START_W; k++)
    begin : g_release
        if (k < SENSOR_CHANNELS)
        begin : g_live
            assign release_next[k] = rel_ch[k];
        end
        else
        begin : g_absent
            assign release_next[k] = 1'b0;
        end
    end

    // State registers, written when the input register hands its beat on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_base_reg    <= '0;
            long_wraps_reg   <= '0;
            medium_base_reg  <= '0;
            medium_wraps_reg <= '0;
            short_base_reg   <= '0;
            short_wraps_reg  <= '0;
            window_count_reg <= '0;
            alarm_events_reg <= '0;
            alarm_level_reg  <= 1'b0;
            for (int i = 0; i < SENSOR_CHANNELS; i++)
            begin
                hold_reg[i] <= '0;
            end
        end
        else if (s1_fire)
        begin
            long_base_reg    <= long_base_next;
            long_wraps_reg   <= long_wraps_next;
            medium_base_reg  <= medium_base_next;
            medium_wraps_reg <= medium_wraps_next;
            short_base_reg   <= short_base_next;
            short_wraps_reg  <= short_wraps_next;
            window_count_reg <= window_count_next;
            alarm_events_reg <= alarm_events_next;
            alarm_level_reg  <= alarm_level_next;
            for (int i = 0; i < SENSOR_CHANNELS; i++)
            begin
                hold_reg[i] <= hold_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic               long_elapsed_reg;
    logic               medium_elapsed_reg;
    logic               short_elapsed_reg;
    logic               window_done_reg;
    logic               battery_alarm_reg;
    logic [START_W-1:0] sensor_release_reg;

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            long_elapsed_reg   <= long_pulse_next;
            medium_elapsed_reg <= medium_pulse_next;
            short_elapsed_reg  <= short_pulse_next;
            window_done_reg    <= window_done_next;
            battery_alarm_reg  <= alarm_level_next;
            sensor_release_reg <= release_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign long_elapsed   = long_elapsed_reg;
    assign medium_elapsed = medium_elapsed_reg;
    assign short_elapsed  = short_elapsed_reg;
    assign window_done    = window_done_reg;
    assign battery_alarm  = battery_alarm_reg;
    assign sensor_release = sensor_release_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A powered-down tick leaves every pulse and release bit low.
    a_power_down_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_opcode_reg == OP_TICK) && s1_power_down_reg) |=>
        (!long_elapsed && !medium_elapsed && !short_elapsed && !window_done &&
         (sensor_release == '0)))
        else $error("powered-down tick produced a pulse");

    // A compensate beat never ends the window and never releases a channel.
    a_comp_no_release: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_opcode_reg == OP_COMPENSATE)) |=>
        (!window_done && (sensor_release == '0)))
        else $error("compensate beat released a channel or ended the window");

    // The event count restarts whenever a window ends.
    a_window_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && window_done_next) |=>
        ((alarm_events_reg == '0) && (window_count_reg == '0)))
        else $error("alarm window did not restart");

    // The battery alarm level changes only at a window end.
    a_alarm_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !window_done_next) |=> $stable(alarm_level_reg))
        else $error("battery alarm changed outside a window end");

    // The input side only stalls while the input register holds a beat.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && result_valid_reg))
        else $error("input stalled with free buffering");

endmodule

// ===== dv/multi_interval_tick_timer_tb.sv =====
// Self-checking testbench for multi_interval_tick_timer: directed and random beats under handshake pressure.
`timescale 1ns / 1ps

module multi_interval_tick_timer_tb;

    import mitt_pkg::*;

    // Register indexes that the block does not decode; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    // One input beat, most significant field first.
    typedef struct packed {
        logic               opcode;
        logic               power_down;
        logic               charging;
        logic               alarm_event;
        logic [START_W-1:0] sensor_start;
    } timer_beat_t;

    // One result beat as the block should present it.
    typedef struct packed {
        logic               long_elapsed;
        logic               medium_elapsed;
        logic               short_elapsed;
        logic               window_done;
        logic               battery_alarm;
        logic [START_W-1:0] sensor_release;
    } timer_result_t;

    // Next value of one base/wrap counter pair.
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [LONG_W-1:0] wraps;
        logic              fired;
    } interval_next_t;

    // Every port starts at a known value; reset is held from time zero.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    logic                   opcode = OP_TICK;
    logic                   power_down = 1'b0;
    logic                   charging = 1'b0;
    logic                   alarm_event = 1'b0;
    logic [START_W-1:0]     sensor_start = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic                   long_elapsed;
    logic                   medium_elapsed;
    logic                   short_elapsed;
    logic                   window_done;
    logic                   battery_alarm;
    logic [START_W-1:0]     sensor_release;

    // Register copies as the timer should currently see them.
    logic [BASE_W-1:0]   cur_period;
    logic [LONG_W-1:0]   cur_long_limit;
    logic [SHORT_W-1:0]  cur_medium_limit;
    logic [SHORT_W-1:0]  cur_short_limit;
    logic [EVENTS_W-1:0] cur_threshold;
    logic [SHORT_W-1:0]  cur_step;

    // Timer state, tracked at the block's own widths.
    logic [BASE_W-1:0]   long_base;
    logic [LONG_W-1:0]   long_wraps;
    logic [BASE_W-1:0]   medium_base;
    logic [SHORT_W-1:0]  medium_wraps;
    logic [BASE_W-1:0]   short_base;
    logic [SHORT_W-1:0]  short_wraps;
    logic [WINDOW_W-1:0] window_count;
    logic [EVENTS_W-1:0] alarm_events;
    logic                alarm_level;
    logic [HOLD_W-1:0]   sensor_hold [4];

    // Results owed by the block, oldest first.
    timer_result_t timer_outputs_q [$];

    int errors = 0;

    // Sender idling: bursts of beats separated by short gaps, or back to back.
    bit sender_bursty = 1'b0;
    int burst_left = 0;

    // Receiver stalling: 0 never, 1 light pattern, 2 heavy pattern. A nonzero
    // hold_left forces a solid stall until it counts down to zero.
    int stall_style = 0;
    int stall_run = 0;
    bit stall_now = 1'b0;
    int hold_left = 0;

    multi_interval_tick_timer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .opcode         (opcode),
        .power_down     (power_down),
        .charging       (charging),
        .alarm_event    (alarm_event),
        .sensor_start   (sensor_start),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .long_elapsed   (long_elapsed),
        .medium_elapsed (medium_elapsed),
        .short_elapsed  (short_elapsed),
        .window_done    (window_done),
        .battery_alarm  (battery_alarm),
        .sensor_release (sensor_release)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs. Far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("multi_interval_tick_timer_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void reset_timer_state();
        int i;
        cur_period       = BASE_PERIOD_RST;
        cur_long_limit   = LONG_LIMIT_RST;
        cur_medium_limit = MEDIUM_LIMIT_RST;
        cur_short_limit  = SHORT_LIMIT_RST;
        cur_threshold    = ALARM_THRESHOLD_RST;
        cur_step         = COMP_STEP_RST;
        long_base        = '0;
        long_wraps       = '0;
        medium_base      = '0;
        medium_wraps     = '0;
        short_base       = '0;
        short_wraps      = '0;
        window_count     = '0;
        alarm_events     = '0;
        alarm_level      = 1'b0;
        for (i = 0; i < 4; i++) begin
            sensor_hold[i] = '0;
        end
    endfunction

    // A base counter wraps once it goes past the period. A tick restarts it at
    // zero, while a compensation step carries the excess over. Each wrap bumps
    // the wrap counter, which itself restarts and fires once past its limit.
    function automatic interval_next_t step_interval(
        input logic [BASE_W-1:0]  base,
        input logic [LONG_W-1:0]  wraps,
        input logic [LONG_W-1:0]  limit,
        input logic [SHORT_W-1:0] add,
        input logic               is_tick
    );
        interval_next_t nx;
        int unsigned    sum;
        int unsigned    count;
        sum      = base + add;
        nx.wraps = wraps;
        nx.fired = 1'b0;
        if (sum > cur_period) begin
            sum   = is_tick ? 0 : sum - cur_period;
            count = wraps + 1;
            if (count > limit) begin
                nx.wraps = '0;
                nx.fired = 1'b1;
            end
            else begin
                nx.wraps = count[LONG_W-1:0];
            end
        end
        // The base keeps only its low bits, which matters once the period is zero.
        nx.base = sum[BASE_W-1:0];
        return nx;
    endfunction

    // Applies one accepted beat to the tracked state and returns its result.
    function automatic timer_result_t advance_timer(input timer_beat_t b);
        timer_result_t  r;
        interval_next_t nx;
        int unsigned    w;
        logic [SHORT_W-1:0] add;
        logic           is_tick;
        int             i;
        r = '0;

        // Alarm events and sensor restarts act on every beat, even powered down.
        if (b.alarm_event && alarm_events != EVENTS_MAX) begin
            alarm_events = alarm_events + 1'b1;
        end
        for (i = 0; i < 4; i++) begin
            if (b.sensor_start[i]) begin
                sensor_hold[i] = '0;
            end
        end

        // A compensation step ignores power_down; a tick is dropped while powered down.
        if (b.opcode == OP_COMPENSATE || !b.power_down) begin
            is_tick = (b.opcode == OP_TICK);
            add     = is_tick ? 8'd1 : cur_step;

            if (is_tick) begin
                for (i = 0; i < 4; i++) begin
                    if (sensor_hold[i] != HOLD_MAX) begin
                        sensor_hold[i] = sensor_hold[i] + 1'b1;
                    end
                    if (sensor_hold[i] > HOLD_RELEASE) begin
                        r.sensor_release[i] = 1'b1;
                    end
                end
            end

            nx = step_interval(long_base, long_wraps, cur_long_limit, add, is_tick);
            long_base       = nx.base;
            long_wraps      = nx.wraps;
            r.long_elapsed  = nx.fired;

            nx = step_interval(medium_base, {5'd0, medium_wraps}, {5'd0, cur_medium_limit},
                               add, is_tick);
            medium_base      = nx.base;
            medium_wraps     = nx.wraps[SHORT_W-1:0];
            r.medium_elapsed = nx.fired;

            nx = step_interval(short_base, {5'd0, short_wraps}, {5'd0, cur_short_limit},
                               add, is_tick);
            short_base      = nx.base;
            short_wraps     = nx.wraps[SHORT_W-1:0];
            r.short_elapsed = nx.fired;

            if (b.charging) begin
                if (is_tick) begin
                    // Window end: judge the events of this window and start a new count.
                    w = window_count + 1;
                    if (w > cur_period) begin
                        w             = 0;
                        r.window_done = 1'b1;
                        alarm_level   = (alarm_events > cur_threshold);
                        alarm_events  = '0;
                    end
                    window_count = w[WINDOW_W-1:0];
                end
                else begin
                    // No end-of-window check on compensation; the count just rolls over.
                    window_count = window_count + cur_step;
                end
            end

            if (!is_tick) begin
                for (i = 0; i < 4; i++) begin
                    sensor_hold[i] = HOLD_PRESET;
                end
            end
        end

        r.battery_alarm = alarm_level;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    // Every result beat is matched against the oldest prediction. Values read at
    // the rising edge are the ones from before the edge, since all drives are
    // nonblocking.
    always @(posedge clk) begin
        timer_result_t want;
        if (rst_n && result_valid && !result_stall) begin
            if (timer_outputs_q.size() == 0) begin
                $error("result beat arrived with no prediction pending");
                errors++;
            end
            else begin
                want = timer_outputs_q.pop_front();
                check_field("long_elapsed", want.long_elapsed, long_elapsed);
                check_field("medium_elapsed", want.medium_elapsed, medium_elapsed);
                check_field("short_elapsed", want.short_elapsed, short_elapsed);
                check_field("window_done", want.window_done, window_done);
                check_field("battery_alarm", want.battery_alarm, battery_alarm);
                check_field("sensor_release", want.sensor_release, sensor_release);
            end
        end
    end

    // Receiver side. A requested hold wins over the pattern; otherwise the stall
    // line alternates between stalled and open runs of random length, with the
    // heavy style favoring long stalls.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_style == 0) begin
            result_stall <= 1'b0;
        end
        else begin
            if (stall_run == 0) begin
                stall_now = !stall_now;
                if (stall_now) begin
                    stall_run = $urandom_range(1, (stall_style == 1) ? 3 : 9);
                end
                else begin
                    stall_run = $urandom_range(1, (stall_style == 1) ? 8 : 3);
                end
            end
            stall_run--;
            result_stall <= stall_now;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic timer_beat_t make_beat(input logic op, input logic pd, input logic chg,
                                              input logic evt, input logic [START_W-1:0] start);
        timer_beat_t b;
        b.opcode       = op;
        b.power_down   = pd;
        b.charging     = chg;
        b.alarm_event  = evt;
        b.sensor_start = start;
        return b;
    endfunction

    // Percentages steer each bit. Sensor restarts are kept to a third of the
    // beats so that hold counters get the chance to climb past the release point.
    function automatic timer_beat_t random_beat(input int comp_pct, input int pd_pct,
                                                input int chg_pct, input int evt_pct);
        timer_beat_t b;
        b.opcode       = ($urandom_range(0, 99) < comp_pct) ? OP_COMPENSATE : OP_TICK;
        b.power_down   = ($urandom_range(0, 99) < pd_pct);
        b.charging     = ($urandom_range(0, 99) < chg_pct);
        b.alarm_event  = ($urandom_range(0, 99) < evt_pct);
        b.sensor_start = ($urandom_range(0, 2) == 0) ? START_W'($urandom_range(0, 15)) : '0;
        return b;
    endfunction

    // Offers one beat and holds it until the block takes it. The valid line
    // stays high on return so that a following beat goes out back to back;
    // it is only lowered by a gap or by quiesce.
    task automatic send_beat(input timer_beat_t b);
        int gap;
        if (sender_bursty && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(1, 6);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        item_valid   <= 1'b1;
        opcode       <= b.opcode;
        power_down   <= b.power_down;
        charging     <= b.charging;
        alarm_event  <= b.alarm_event;
        sensor_start <= b.sensor_start;
        do begin
            @(posedge clk);
        end while (item_stall);
        timer_outputs_q.push_back(advance_timer(b));
    endtask

    task automatic send_random(input int count, input int comp_pct, input int pd_pct,
                               input int chg_pct, input int evt_pct);
        repeat (count) begin
            send_beat(random_beat(comp_pct, pd_pct, chg_pct, evt_pct));
        end
    endtask

    // Stops offering beats and waits for every owed result. Once that holds the
    // block is idle, because each beat produces exactly one result.
    task automatic quiesce();
        item_valid <= 1'b0;
        while (timer_outputs_q.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // The enable is lowered again after each write, so that it drops between writes.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (index)
            REG_BASE_PERIOD:     cur_period       = data[BASE_W-1:0];
            REG_LONG_LIMIT:      cur_long_limit   = data[LONG_W-1:0];
            REG_MEDIUM_LIMIT:    cur_medium_limit = data[SHORT_W-1:0];
            REG_SHORT_LIMIT:     cur_short_limit  = data[SHORT_W-1:0];
            REG_ALARM_THRESHOLD: cur_threshold    = data[EVENTS_W-1:0];
            REG_COMP_STEP:       cur_step         = data[SHORT_W-1:0];
            default:             ;
        endcase
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] period,
                             input logic [CFG_DATA_W-1:0] long_lim,
                             input logic [CFG_DATA_W-1:0] medium_lim,
                             input logic [CFG_DATA_W-1:0] short_lim,
                             input logic [CFG_DATA_W-1:0] threshold,
                             input logic [CFG_DATA_W-1:0] step);
        write_reg(REG_BASE_PERIOD, period);
        write_reg(REG_LONG_LIMIT, long_lim);
        write_reg(REG_MEDIUM_LIMIT, medium_lim);
        write_reg(REG_SHORT_LIMIT, short_lim);
        write_reg(REG_ALARM_THRESHOLD, threshold);
        write_reg(REG_COMP_STEP, step);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings, no idling. Covers sensor restart and release, the hold
    // counter saturating, a powered-down tick, and compensation both powered
    // up and powered down.
    task automatic test_directed_basics();
        int k;
        quiesce();
        sender_bursty = 1'b0;
        stall_style   = 0;
        send_beat(make_beat(OP_TICK, 1'b0, 1'b0, 1'b0, 4'h0));
        // Restart all channels; the third tick after this releases them.
        send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 1'b1, 4'hF));
        send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 1'b0, 4'h0));
        send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 1'b0, 4'h0));
        send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 1'b0, 4'h0));
        // Powered down: restarts and the event still count, nothing else moves.
        send_beat(make_beat(OP_TICK, 1'b1, 1'b1, 1'b1, 4'b0101));
        send_beat(make_beat(OP_TICK, 1'b0, 1'b0, 1'b0, 4'b1010));
        send_beat(make_beat(OP_COMPENSATE, 1'b1, 1'b1, 1'b1, 4'hF));
        send_beat(make_beat(OP_TICK, 1'b0, 1'b0, 1'b0, 4'h0));
        send_beat(make_beat(OP_COMPENSATE, 1'b0, 1'b0, 1'b0, 4'h0));
        // Enough ticks from the preset to pin every hold counter at its maximum.
        for (k = 0; k < 11; k++) begin
            send_beat(make_beat(OP_TICK, 1'b0, k[0], 1'b1, 4'h0));
        end
    endtask

    task automatic test_unknown_index();
        quiesce();
        write_reg(REG_SPARE_LO, 14'h3FFF);
        write_reg(REG_SPARE_HI, 14'h0001);
        send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 1'b1, 4'h0));
        send_beat(make_beat(OP_COMPENSATE, 1'b0, 1'b1, 1'b0, 4'h3));
        send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 1'b0, 4'h0));
    endtask

    // With a zero period every tick wraps and every charging tick closes a
    // window. A run of compensation steps then pushes the base counters past
    // their width, since nothing is subtracted.
    task automatic test_zero_period();
        int k;
        quiesce();
        write_all(14'd0, 14'd1, 14'd2, 14'd1, 14'd0, 14'd255);
        for (k = 0; k < 6; k++) begin
            send_beat(make_beat(OP_TICK, 1'b0, 1'b1, k[1], 4'h0));
        end
        sender_bursty = 1'b1;
        stall_style   = 1;
        send_random(80, 90, 50, 50, 50);
    endtask

    // Charging compensation steps at the largest step roll the window counter
    // over its 16 bits. The period is then lowered below the rolled-over count,
    // so the first charging tick after that closes the window.
    task automatic test_window_rollover();
        quiesce();
        write_all(14'd16000, 14'd3, 14'd2, 14'd1, 14'd3, 14'd255);
        stall_style = 2;
        send_random(300, 100, 50, 100, 50);
        quiesce();
        write_reg(REG_BASE_PERIOD, 14'd100);
        send_random(20, 0, 0, 100, 50);
    endtask

    // The event count saturates at its maximum. A threshold one below it raises
    // the alarm; the threshold at the maximum itself keeps it clear. A zero
    // period lets the one charging tick close the window right away.
    task automatic test_event_saturation();
        quiesce();
        write_reg(REG_BASE_PERIOD, 14'd0);
        write_reg(REG_ALARM_THRESHOLD, CFG_DATA_W'(EVENTS_MAX - 1'b1));
        stall_style = 1;
        send_random(262, 20, 30, 0, 100);
        send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 1'b0, 4'h0));
        quiesce();
        write_reg(REG_ALARM_THRESHOLD, CFG_DATA_W'(EVENTS_MAX));
        send_random(258, 20, 30, 0, 100);
        send_beat(make_beat(OP_TICK, 1'b0, 1'b1, 1'b1, 4'h0));
    endtask

    // Phases under changing settings. The first uses the highest values, the
    // last the lowest; in between, mostly short periods and small limits keep
    // pulses frequent. State carries across phases, so limits often drop below
    // a wrap count already reached. Upper data bits beyond a register's width
    // are filled with junk, which the block must drop.
    task automatic test_random_settings();
        int p;
        int period;
        int sel;
        for (p = 0; p < 8; p++) begin
            quiesce();
            sender_bursty = (p % 3) != 2;
            stall_style   = p % 3;
            if (p == 0) begin
                write_all(14'd16000, 14'd8191, 14'd255, 14'd255, 14'd255, 14'd255);
            end
            else if (p == 7) begin
                write_all(14'd1, 14'd1, 14'd1, 14'd1, 14'd0, 14'd0);
            end
            else begin
                sel = $urandom_range(0, 9);
                if (sel < 6) begin
                    period = $urandom_range(1, 6);
                end
                else if (sel < 9) begin
                    period = $urandom_range(7, 60);
                end
                else begin
                    period = $urandom_range(61, 16000);
                end
                write_all(CFG_DATA_W'(period),
                          CFG_DATA_W'(($urandom_range(0, 1) << 13) | $urandom_range(1, 4)),
                          CFG_DATA_W'(($urandom_range(0, 63) << 8) | $urandom_range(1, 5)),
                          CFG_DATA_W'(($urandom_range(0, 63) << 8) | $urandom_range(1, 5)),
                          CFG_DATA_W'(($urandom_range(0, 63) << 8) | $urandom_range(0, 3)),
                          CFG_DATA_W'(($urandom_range(0, 63) << 8) | $urandom_range(0, 255)));
            end
            send_random(25, 15, 20, 50, 50);
        end
    endtask

    // The receiver holds off for a long stretch while beats keep coming back to
    // back, so both internal registers fill and the input stalls. Afterwards the
    // sender pauses until every owed result is in, then resumes in bursts.
    task automatic test_backpressure();
        quiesce();
        write_all(14'd2, 14'd2, 14'd1, 14'd1, 14'd1, 14'd3);
        sender_bursty = 1'b0;
        stall_style   = 0;
        hold_left     = 300;
        send_random(60, 15, 20, 50, 50);
        quiesce();
        sender_bursty = 1'b1;
        stall_style   = 1;
        send_random(40, 15, 20, 50, 50);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        reset_timer_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_unknown_index();
        test_zero_period();
        test_window_rollover();
        test_event_saturation();
        test_random_settings();
        test_backpressure();

        // Drain, then give any stray result beat time to show up.
        quiesce();
        stall_style = 0;
        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("multi_interval_tick_timer_tb: PASS");
        end
        else begin
            $display("multi_interval_tick_timer_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/mitt_pkg.sv
design/multi_interval_tick_timer.sv
dv/multi_interval_tick_timer_tb.sv
